[rtl/aoc_pkg.sv]
package aoc_pkg;

  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned AverageShift  = 4;

  localparam int unsigned NumCh   = 4;
  localparam int unsigned SumW    = 19;
  localparam int unsigned OffW    = 15;
  localparam int unsigned CntW    = 17;
  localparam int unsigned DacW    = 9;
  localparam int unsigned DivW    = 11;
  localparam int unsigned ValW    = 16;
  localparam int unsigned OutW    = 72;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [SumW-1:0] SumReset    = 19'd16383;
  localparam logic [7:0]      DacClampMax = 8'd250;

  // register map
  localparam logic [CfgIdxW-1:0] CfgShuntMode    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCalibSamples = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOffsetMax    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOffsetMin    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDacDivisor   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDacBase      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDacFloor     = 3'd6;

  // shunt modes
  localparam logic [1:0] ModeBus    = 2'd0;
  localparam logic [1:0] ModeTwoBus = 2'd1;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_ACC    = 13'b0000000000010,
    S_LEAK   = 13'b0000000000100,
    S_COUNT  = 13'b0000000001000,
    S_CMPCNT = 13'b0000000010000,
    S_CHKHI  = 13'b0000000100000,
    S_CHKLO  = 13'b0000001000000,
    S_DIV    = 13'b0000010000000,
    S_DACADD = 13'b0000100000000,
    S_CLAMP  = 13'b0001000000000,
    S_FLOOR  = 13'b0010000000000,
    S_FADD   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

endpackage

[rtl/adc_offset_calibrator_unit.sv]
// Power-up offset calibration for the current-sense ADC channels. Each input
// transfer carries one set of raw samples (U, V, W, bus). Until calibration is
// done, every channel in use (per shunt_mode) scales its sample by 8 and runs a
// leaky average; once the sample count exceeds calib_samples, done is set and
// the checked offsets are tested against [offset_min, offset_max], raising a
// sticky fault. In shunt modes 0 and 1 a DAC over-current code is formed from
// bus_offset / dac_divisor + dac_base, capped at 250, raised to dac_floor if
// below it, plus dac_floor, and written on every calibrating step. After done,
// inputs are ignored and the held state repeats. Every input produces exactly
// one output transfer. All arithmetic runs through one shared 19-bit add/subtract
// unit under a small sequencer, so the block takes one item at a time: averaging
// and count compare, in modes 0 and 1 the divide and the DAC steps, plus window
// checks on the item that finishes calibration. The 15-step restoring divide is
// the longest leg. A finished result sits in an output register, so the next
// item is taken while it waits. The config port is always ready and must only be
// written while the block is idle.
module adc_offset_calibrator_unit #(
  parameter  int unsigned SAMPLE_BITS = aoc_pkg::SampleBitsDef,
  localparam int unsigned InW         = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aoc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [aoc_pkg::CfgDatW-1:0]  cfg_data_i,

  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // u_sample, v_sample, w_sample, bus_sample (SAMPLE_BITS each), zero pad
  input  logic [InW-1:0]               s_axis_tdata,

  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // u_offset[14:0], v_offset[29:15], w_offset[44:30], bus_offset[59:45],
  // done_res[60], fault[61], dac_code[70:62], dac_valid[71]
  output logic [aoc_pkg::OutW-1:0]     m_axis_tdata
);
  import aoc_pkg::*;

  // configuration registers
  logic [1:0]      mode_q;
  logic [15:0]     calib_q;
  logic [OffW-1:0] omax_q, omin_q;
  logic [DivW-1:0] ddiv_q;
  logic [7:0]      dbase_q, dfloor_q;

  // calibration state
  logic [SumW-1:0] sums_q [NumCh];
  logic [SumW-1:0] sums_d [NumCh];
  logic [OffW-1:0] offs_q [NumCh];
  logic [OffW-1:0] offs_d [NumCh];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic            fault_q, fault_d;
  logic [DacW-1:0] dac_q, dac_d;

  // sequencer and work registers
  state_e            state_q, state_d;
  logic [1:0]        ch_q, ch_d;
  logic              dac_wr_q, dac_wr_d;
  logic [SAMPLE_BITS-1:0] samp_q [NumCh];
  logic [SAMPLE_BITS-1:0] samp_d [NumCh];
  logic [SumW-1:0]   acc_q, acc_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [OffW-1:0]   quo_q, quo_d;
  logic [3:0]        bit_q, bit_d;
  logic [ValW-1:0]   val_q, val_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [OutW-1:0]   out_data_q, out_data_d;

  // shared unit
  alu_op_e         alu_op;
  logic [SumW-1:0] alu_a, alu_b, alu_res;
  logic            alu_cy;

  aoc_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_cy)
  );

  logic [NumCh-1:0] used_mask, chk_mask;
  logic             dac_mode;
  logic [SumW-1:0]  x_scaled;
  logic [OffW-1:0]  leak_off;
  logic [DivW:0]    rem_sh;
  logic [DivW-1:0]  div_eff;
  state_e           dac_next;
  logic             in_xfer, out_free;

  always_comb begin
    case (mode_q)
      ModeBus: begin
        used_mask = 4'b1000;
        chk_mask  = 4'b1000;
      end
      ModeTwoBus: begin
        used_mask = 4'b1011;
        chk_mask  = 4'b0011;
      end
      default: begin  // mode 2, and the unused code behaves the same
        used_mask = 4'b0111;
        chk_mask  = 4'b0111;
      end
    endcase
  end

  assign dac_mode = (mode_q == ModeBus) || (mode_q == ModeTwoBus);
  assign dac_next = dac_mode ? S_DIV : S_OUT;
  assign x_scaled = SumW'({samp_q[ch_q], 3'b000});
  assign leak_off = OffW'(acc_q >> AverageShift);
  assign rem_sh   = {rem_q, quo_q[OffW-1]};
  assign div_eff  = (ddiv_q == '0) ? DivW'(1) : ddiv_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // operand select for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      S_ACC: begin
        alu_a = sums_q[ch_q];
        alu_b = x_scaled;
      end
      S_LEAK: begin
        alu_op = ALU_SUB;
        alu_a  = acc_q;
        alu_b  = SumW'(leak_off);
      end
      S_COUNT: begin
        alu_a = SumW'(cnt_q);
        alu_b = SumW'(1);
      end
      S_CMPCNT: begin
        alu_op = ALU_SUB;
        alu_a  = SumW'(calib_q);
        alu_b  = SumW'(cnt_q);
      end
      S_CHKHI: begin
        alu_op = ALU_SUB;
        alu_a  = SumW'(omax_q);
        alu_b  = SumW'(offs_q[ch_q]);
      end
      S_CHKLO: begin
        alu_op = ALU_SUB;
        alu_a  = SumW'(offs_q[ch_q]);
        alu_b  = SumW'(omin_q);
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = SumW'(rem_sh);
        alu_b  = SumW'(div_eff);
      end
      S_DACADD: begin
        alu_a = SumW'(quo_q);
        alu_b = SumW'(dbase_q);
      end
      S_CLAMP: begin
        alu_op = ALU_SUB;
        alu_a  = SumW'(DacClampMax);
        alu_b  = SumW'(val_q);
      end
      S_FLOOR: begin
        alu_op = ALU_SUB;
        alu_a  = SumW'(val_q);
        alu_b  = SumW'(dfloor_q);
      end
      S_FADD: begin
        alu_a = SumW'(val_q);
        alu_b = SumW'(dfloor_q);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    dac_wr_d = dac_wr_q;
    samp_d   = samp_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    bit_d    = bit_q;
    val_d    = val_q;
    sums_d   = sums_q;
    offs_d   = offs_q;
    cnt_d    = cnt_q;
    done_d   = done_q;
    fault_d  = fault_q;
    dac_d    = dac_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          for (int i = 0; i < NumCh; i++) begin
            samp_d[i] = s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
          end
          dac_wr_d = 1'b0;
          ch_d     = '0;
          state_d  = done_q ? S_OUT : S_ACC;
        end
      end
      S_ACC: begin
        acc_d   = alu_res;
        state_d = S_LEAK;
      end
      S_LEAK: begin
        if (used_mask[ch_q]) begin
          sums_d[ch_q] = alu_res;
          offs_d[ch_q] = leak_off;
        end
        ch_d = ch_q + 2'd1;
        state_d = (ch_q == 2'd3) ? S_COUNT : S_ACC;
      end
      S_COUNT: begin
        cnt_d   = alu_res[CntW-1:0];
        state_d = S_CMPCNT;
      end
      S_CMPCNT: begin
        if (alu_cy) begin  // count now above calib_samples
          done_d  = 1'b1;
          ch_d    = '0;
          state_d = S_CHKHI;
        end else begin
          state_d = dac_next;
        end
      end
      S_CHKHI: begin
        if (chk_mask[ch_q] && alu_cy) fault_d = 1'b1;
        state_d = S_CHKLO;
      end
      S_CHKLO: begin
        if (chk_mask[ch_q] && alu_cy) fault_d = 1'b1;
        ch_d = ch_q + 2'd1;
        state_d = (ch_q == 2'd3) ? dac_next : S_CHKHI;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (alu_cy) begin
          rem_d = rem_sh[DivW-1:0];
        end else begin
          rem_d = alu_res[DivW-1:0];
        end
        quo_d = {quo_q[OffW-2:0], !alu_cy};
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'(OffW - 1)) state_d = S_DACADD;
      end
      S_DACADD: begin
        val_d   = alu_res[ValW-1:0];
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        if (alu_cy) val_d = ValW'(DacClampMax);
        state_d = S_FLOOR;
      end
      S_FLOOR: begin
        if (alu_cy) val_d = ValW'(dfloor_q);
        state_d = S_FADD;
      end
      S_FADD: begin
        dac_d    = alu_res[DacW-1:0];
        dac_wr_d = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // divider setup on entry
    if (state_d == S_DIV && state_q != S_DIV) begin
      rem_d = '0;
      quo_d = offs_d[3];
      bit_d = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (state_q == S_OUT && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = {dac_wr_q, dac_q, fault_q, done_q,
                     offs_q[3], offs_q[2], offs_q[1], offs_q[0]};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 2'd2;
      calib_q  <= 16'd512;
      omax_q   <= 15'd18000;
      omin_q   <= 15'd14000;
      ddiv_q   <= 11'd64;
      dbase_q  <= 8'd100;
      dfloor_q <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgShuntMode:    mode_q   <= cfg_data_i[1:0];
        CfgCalibSamples: calib_q  <= cfg_data_i;
        CfgOffsetMax:    omax_q   <= cfg_data_i[OffW-1:0];
        CfgOffsetMin:    omin_q   <= cfg_data_i[OffW-1:0];
        CfgDacDivisor:   ddiv_q   <= cfg_data_i[DivW-1:0];
        CfgDacBase:      dbase_q  <= cfg_data_i[7:0];
        CfgDacFloor:     dfloor_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      dac_wr_q    <= 1'b0;
      bit_q       <= '0;
      sums_q      <= '{default: SumReset};
      offs_q      <= '{default: '0};
      cnt_q       <= '0;
      done_q      <= 1'b0;
      fault_q     <= 1'b0;
      dac_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      dac_wr_q    <= dac_wr_d;
      bit_q       <= bit_d;
      sums_q      <= sums_d;
      offs_q      <= offs_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      fault_q     <= fault_d;
      dac_q       <= dac_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath work registers
  always_ff @(posedge clk_i) begin
    samp_q     <= samp_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

endmodule

[rtl/aoc_alu.sv]
module aoc_alu (
  input  aoc_pkg::alu_op_e                op_i,
  input  logic [aoc_pkg::SumW-1:0]        a_i,
  input  logic [aoc_pkg::SumW-1:0]        b_i,
  output logic [aoc_pkg::SumW-1:0]        res_o,
  output logic                            carry_o  // carry on add, borrow (a < b) on sub
);
  import aoc_pkg::*;

  logic [SumW:0] full;

  always_comb begin
    case (op_i)
      ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default: full = '0;
    endcase
  end

  assign res_o   = full[SumW-1:0];
  assign carry_o = full[SumW];

endmodule
